### hdl/mmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_pkg: shared types and constants
// Widths, operation codes and the queue word for the matrix multiply block.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int unsigned MaxDim    = 64;
  localparam int unsigned ElemWidth = 16;
  localparam int unsigned Depth     = MaxDim * MaxDim;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned IdxW      = $clog2(MaxDim);
  localparam int unsigned DimW      = 7;
  localparam int unsigned ProdW     = 2 * ElemWidth;
  localparam int unsigned AccW      = ProdW + IdxW + 2;

  localparam logic [1:0] OpWriteA = 2'd0;
  localparam logic [1:0] OpWriteB = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  localparam logic [1:0] ModeAB  = 2'd0;
  localparam logic [1:0] ModeABt = 2'd1;
  localparam logic [1:0] ModeAtB = 2'd2;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegDimM = 2'd1;
  localparam logic [1:0] RegDimN = 2'd2;
  localparam logic [1:0] RegDimK = 2'd3;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // One classified query handed from front to back.
  typedef struct packed {
    logic            range_err;
    logic [DimW-1:0] inner;
    logic [AddrW:0]  a_base;
    logic [AddrW:0]  a_step;
    logic [AddrW:0]  b_base;
    logic [AddrW:0]  b_step;
  } job_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = (d > DimW'(MaxDim)) ? DimW'(MaxDim) : d;
    return r;
  endfunction

endpackage

### hdl/matrix_multiply_with_transpose.sv
`timescale 1ns / 1ps
// Throughput: one write per cycle while no query is queued or running.
// The single MAC works on one query at a time.
// A queue of four queries lets queries be accepted while the MAC is busy; a write waits
// until every accepted query has finished.
// Reset clears control and registers; store contents stay undefined until written.
// ----------------------------------------------------------------------------
// matrix_multiply_with_transpose: GEMM entry engine with transpose modes
// Two element stores and one multiply-accumulate unit answering C queries.
// ----------------------------------------------------------------------------
module matrix_multiply_with_transpose
  import mmt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [11:0]        address_i,
  input  logic signed [15:0] value_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] dot_value_o,
  output logic               range_error_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);

  logic [1:0]            mode_q;
  logic [DimW-1:0]       m_q, n_q, k_q;
  logic                  q_full, q_empty, q_push, q_pop;
  logic                  back_busy, busy;
  job_t                  job_in, job_out;
  logic                  we_a, we_b;
  logic [AddrW-1:0]      waddr, ra, rb;
  logic [ElemWidth-1:0]  da, db;
  logic [31:0]           dot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeAB;
      m_q    <= DimW'(64);
      n_q    <= DimW'(64);
      k_q    <= DimW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMode: mode_q <= cfg_data_i[1:0];
        RegDimM: m_q    <= cfg_data_i;
        RegDimN: n_q    <= cfg_data_i;
        RegDimK: k_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = !q_empty || back_busy;

  mmt_front u_front (
    .in_valid_i, .in_stall_o, .op_i, .address_i,
    .mode_i(mode_q), .m_i(clamp_dim(m_q)), .n_i(clamp_dim(n_q)), .k_i(clamp_dim(k_q)),
    .row_i, .col_i, .q_full_i(q_full), .busy_i(busy), .q_push_o(q_push), .q_job_o(job_in),
    .we_a_o(we_a), .we_b_o(we_b), .waddr_o(waddr)
  );

  mmt_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .job_i(job_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .job_o(job_out)
  );

  mmt_ram #(.Width(ElemWidth), .Depth(Depth)) u_ram_a (
    .clk_i, .we_i(we_a), .waddr_i(waddr), .wdata_i(ElemWidth'(value_i)),
    .raddr_i(ra), .rdata_o(da)
  );

  mmt_ram #(.Width(ElemWidth), .Depth(Depth)) u_ram_b (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(ElemWidth'(value_i)),
    .raddr_i(rb), .rdata_o(db)
  );

  mmt_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .job_i(job_out), .q_pop_o(q_pop),
    .busy_o(back_busy),
    .raddr_a_o(ra), .raddr_b_o(rb), .rdata_a_i(da), .rdata_b_i(db),
    .out_valid_o, .out_stall_i, .dot_value_o(dot), .range_error_o
  );

  assign dot_value_o = $signed(dot);

endmodule

### hdl/mmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/mmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_front: input classification
// Accepts words, performs store writes and turns queries into queued jobs.
// ----------------------------------------------------------------------------
module mmt_front
  import mmt_pkg::*;
(
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [11:0]          address_i,
  input  logic [1:0]           mode_i,
  input  logic [DimW-1:0]      m_i,
  input  logic [DimW-1:0]      n_i,
  input  logic [DimW-1:0]      k_i,
  input  logic [5:0]           row_i,
  input  logic [5:0]           col_i,
  input  logic                 q_full_i,
  input  logic                 busy_i,
  output logic                 q_push_o,
  output job_t                 q_job_o,
  output logic                 we_a_o,
  output logic                 we_b_o,
  output logic [AddrW-1:0]     waddr_o
);

  logic            acc;
  logic            is_write;
  logic [DimW-1:0] rows, inner;
  logic [AddrW:0]  rn, cn;

  // A write must not overtake a query that still has to read the stores.
  assign is_write   = (op_i == OpWriteA) || (op_i == OpWriteB);
  assign in_stall_o = q_full_i || (busy_i && is_write);
  assign acc        = in_valid_i && !in_stall_o;

  assign rows  = (mode_i == ModeAtB) ? n_i : m_i;
  assign inner = (mode_i == ModeAtB) ? m_i : n_i;
  assign rn    = (AddrW+1)'(row_i * n_i);
  assign cn    = (AddrW+1)'(col_i * n_i);

  assign waddr_o  = AddrW'(address_i);
  assign we_a_o   = acc && (op_i == OpWriteA) && ({1'b0, address_i} < 13'(Depth));
  assign we_b_o   = acc && (op_i == OpWriteB) && ({1'b0, address_i} < 13'(Depth));
  assign q_push_o = acc && (op_i == OpQuery);

  always_comb begin
    q_job_o.range_err = ({1'b0, row_i} >= rows) || ({1'b0, col_i} >= k_i);
    q_job_o.inner     = inner;
    unique case (mode_i)
      ModeABt: begin
        q_job_o.a_base = rn;
        q_job_o.a_step = (AddrW+1)'(1);
        q_job_o.b_base = cn;
        q_job_o.b_step = (AddrW+1)'(1);
      end
      ModeAtB: begin
        q_job_o.a_base = (AddrW+1)'(row_i);
        q_job_o.a_step = (AddrW+1)'(n_i);
        q_job_o.b_base = (AddrW+1)'(col_i);
        q_job_o.b_step = (AddrW+1)'(k_i);
      end
      default: begin
        q_job_o.a_base = rn;
        q_job_o.a_step = (AddrW+1)'(1);
        q_job_o.b_base = (AddrW+1)'(col_i);
        q_job_o.b_step = (AddrW+1)'(k_i);
      end
    endcase
  end

endmodule

### hdl/mmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_queue: job queue
// Small FIFO of classified queries between the front and the back.
// ----------------------------------------------------------------------------
module mmt_queue
  import mmt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t           mem_q [QDepth];
  logic [QPtrW:0] wr_q, rd_q;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[QPtrW] != rd_q[QPtrW]) && (wr_q[QPtrW-1:0] == rd_q[QPtrW-1:0]);
  assign job_o   = mem_q[rd_q[QPtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[QPtrW-1:0]] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) <= (QPtrW+1)'(QDepth)) else $error("queue count");

endmodule

### hdl/mmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_back: dot-product engine
// Walks one job through the stores with a single multiply-accumulate unit.
// ----------------------------------------------------------------------------
module mmt_back
  import mmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  job_t                 job_i,
  output logic                 q_pop_o,
  output logic                 busy_o,
  output logic [AddrW-1:0]     raddr_a_o,
  output logic [AddrW-1:0]     raddr_b_o,
  input  logic [ElemWidth-1:0] rdata_a_i,
  input  logic [ElemWidth-1:0] rdata_b_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          dot_value_o,
  output logic                 range_error_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]        st_q, st_d;
  job_t              job_q;
  logic [DimW-1:0]   cnt_q;
  logic [AddrW:0]    pa_q, pb_q;
  logic              rd_v_q, mul_v_q, last_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic              fin_q;
  logic [31:0]       dot_q;
  logic              err_q;

  assign raddr_a_o     = pa_q[AddrW-1:0];
  assign raddr_b_o     = pb_q[AddrW-1:0];
  assign out_valid_o   = (st_q == StOut);
  assign dot_value_o   = dot_q;
  assign range_error_o = err_q;
  assign q_pop_o       = (st_q == StIdle) && !q_empty_i;
  assign busy_o        = (st_q != StIdle);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (!q_empty_i) st_d = StRun;
      StRun:  if (fin_q) st_d = StOut;
      StOut:  if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      fin_q   <= 1'b0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      fin_q   <= 1'b0;
      rd_v_q  <= 1'b0;
      mul_v_q <= rd_v_q;
      if (q_pop_o) begin
        cnt_q  <= job_i.inner;
        last_q <= job_i.range_err || (job_i.inner == '0);
      end else if (st_q == StRun && !last_q) begin
        rd_v_q <= 1'b1;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == DimW'(1)) last_q <= 1'b1;
      end else if (st_q == StRun && !rd_v_q && !mul_v_q && !fin_q) begin
        fin_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= job_i;
      pa_q  <= job_i.a_base;
      pb_q  <= job_i.b_base;
      acc_q <= '0;
    end else if (st_q == StRun && !last_q) begin
      pa_q <= pa_q + job_q.a_step;
      pb_q <= pb_q + job_q.b_step;
    end
    prod_q <= $signed(rdata_a_i) * $signed(rdata_b_i);
    if (mul_v_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (fin_q) begin
      err_q <= job_q.range_err;
      if (job_q.range_err) dot_q <= '0;
      else if (acc_q > AccW'(32'sh7fffffff)) dot_q <= 32'h7fffffff;
      else if (acc_q < -AccW'(64'sd2147483648)) dot_q <= 32'h80000000;
      else dot_q <= acc_q[31:0];
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> st_q == StRun) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(dot_value_o))
    else $error("result dropped");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> dot_value_o == '0) else $error("error value");

endmodule

### sim/matrix_multiply_with_transpose_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_with_transpose_test: self-checking testbench
// Loads both element stores, then sends writes and C entry queries under every
// mode, several dimension settings and varied idling, and compares each
// returned word with a local saturating integer predictor of the dot product.
// ----------------------------------------------------------------------------
module matrix_multiply_with_transpose_test;
  import mmt_pkg::*;

  typedef struct {
    logic signed [31:0] dot;
    logic               rerr;
  } c_entry_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OpWriteA;
  logic [11:0]        address_i = '0;
  logic signed [15:0] value_i = '0;
  logic [5:0]         row_i = '0;
  logic [5:0]         col_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] dot_value_o;
  logic               range_error_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = RegMode;
  logic [6:0]         cfg_data_i = '0;

  logic signed [15:0] a_elems [Depth];
  logic signed [15:0] b_elems [Depth];
  logic [1:0]         cur_mode;
  logic [6:0]         cur_m, cur_n, cur_k;
  c_entry_t           pending_entries [$];
  int                 sender_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_cnt = 0;
  int                 mismatches = 0;
  int                 queries_sent = 0;
  int                 writes_sent = 0;
  int                 entries_checked = 0;
  int                 range_errors_seen = 0;

  matrix_multiply_with_transpose u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .value_i      (value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_value_o  (dot_value_o),
    .range_error_o(range_error_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Outputs and stalls only move at rising edges, so the falling edge sees
  // exactly what the next rising edge will accept.
  always @(negedge clk_i) begin
    c_entry_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: dot=%0d range_error=%0b", dot_value_o, range_error_o);
        end
      end else begin
        e = pending_entries.pop_front();
        entries_checked++;
        if (range_error_o) range_errors_seen++;
        if (dot_value_o !== e.dot || range_error_o !== e.rerr) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected dot=%0d range_error=%0b, got dot=%0d range_error=%0b",
                     e.dot, e.rerr, dot_value_o, range_error_o);
          end
        end
      end
    end
  end

  function automatic int unsigned eff_dim(input logic [6:0] d);
    return (d > MaxDim) ? MaxDim : int'(d);
  endfunction

  function automatic void predict_word(input logic [1:0] op, input logic [11:0] addr,
                                       input logic signed [15:0] val,
                                       input logic [5:0] row, input logic [5:0] col);
    int unsigned m, n, k, rows, cols, inner, ia, ib;
    longint      acc;
    c_entry_t    e;
    m = eff_dim(cur_m);
    n = eff_dim(cur_n);
    k = eff_dim(cur_k);
    case (op)
      OpWriteA: a_elems[addr] = val;
      OpWriteB: b_elems[addr] = val;
      OpQuery: begin
        if (cur_mode == ModeAtB) begin
          rows = n;
          inner = m;
        end else begin
          rows = m;
          inner = n;
        end
        cols = k;
        if (row >= rows || col >= cols) begin
          e.dot = '0;
          e.rerr = 1'b1;
        end else begin
          acc = 0;
          for (int unsigned l = 0; l < inner; l++) begin
            if (cur_mode == ModeABt) begin
              ia = row * n + l;
              ib = col * n + l;
            end else if (cur_mode == ModeAtB) begin
              ia = l * n + row;
              ib = l * k + col;
            end else begin
              ia = row * n + l;
              ib = l * k + col;
            end
            acc += longint'(a_elems[ia]) * longint'(b_elems[ib]);
          end
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          e.dot = acc[31:0];
          e.rerr = 1'b0;
        end
        pending_entries.push_back(e);
        queries_sent++;
      end
      default: ;
    endcase
    if (op == OpWriteA || op == OpWriteB) writes_sent++;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [11:0] addr,
                           input logic signed [15:0] val,
                           input logic [5:0] row, input logic [5:0] col);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    address_i <= addr;
    value_i <= val;
    row_i <= row;
    col_i <= col;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_word(op, addr, val, row, col);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_entries.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMode: cur_mode = data[1:0];
      RegDimM: cur_m = data;
      RegDimN: cur_n = data;
      default: cur_k = data;
    endcase
  endtask

  task automatic configure(input logic [1:0] md, input logic [6:0] m,
                           input logic [6:0] n, input logic [6:0] k);
    drain();
    write_reg(RegMode, {5'd0, md});
    write_reg(RegDimM, m);
    write_reg(RegDimN, n);
    write_reg(RegDimK, k);
  endtask

  function automatic logic signed [15:0] rand_elem;
    if ($urandom_range(3) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(1024))) - 16'sd512;
  endfunction

  function automatic logic [5:0] rand_index(input int unsigned lim);
    if (lim == 0 || $urandom_range(9) == 0) return 6'($urandom_range(63));
    return 6'($urandom_range(lim - 1));
  endfunction

  task automatic random_query;
    int unsigned rows;
    rows = (cur_mode == ModeAtB) ? eff_dim(cur_n) : eff_dim(cur_m);
    send_word(OpQuery, 12'($urandom), 16'($urandom),
              rand_index(rows), rand_index(eff_dim(cur_k)));
  endtask

  // Dimensions stay at or below eight, so in-shape queries read only the
  // first 64 entries of each store.
  function automatic logic [6:0] pick_dim;
    case ($urandom_range(9))
      0: return 7'd1;
      1: return 7'd8;
      default: return 7'($urandom_range(8, 1));
    endcase
  endfunction

  // The first 64 entries of each store are written before any query, and no
  // query ever reads beyond them.
  task automatic test_preload;
    for (int i = 0; i < 64; i++) send_word(OpWriteA, 12'(i), rand_elem(), 6'd0, 6'd0);
    for (int i = 0; i < 64; i++) send_word(OpWriteB, 12'(i), rand_elem(), 6'd0, 6'd0);
    configure(ModeAB, 7'd8, 7'd8, 7'd8);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd0, 6'd0);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd7, 6'd7);
  endtask

  task automatic test_saturation;
    configure(ModeAB, 7'd2, 7'd4, 7'd2);
    for (int i = 0; i < 8; i++) send_word(OpWriteA, 12'(i), -16'sd32768, 6'd0, 6'd0);
    for (int l = 0; l < 4; l++) begin
      send_word(OpWriteB, 12'(l * 2), -16'sd32768, 6'd0, 6'd0);
      send_word(OpWriteB, 12'(l * 2 + 1), 16'sd32767, 6'd0, 6'd0);
    end
    send_word(OpQuery, 12'd0, 16'sd0, 6'd0, 6'd0);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd1, 6'd1);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd2, 6'd0);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd0, 6'd2);
    send_word(2'd3, 12'hFFF, 16'sh7FFF, 6'd63, 6'd63);
  endtask

  task automatic test_special_settings;
    configure(2'd3, 7'd3, 7'd5, 7'd4);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd2, 6'd3);
    configure(ModeAB, 7'd0, 7'd5, 7'd4);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd0, 6'd0);
    configure(ModeAB, 7'd4, 7'd0, 7'd4);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd1, 6'd1);
    configure(ModeAtB, 7'd0, 7'd3, 7'd3);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd2, 6'd2);
    configure(ModeABt, 7'd127, 7'd100, 7'd65);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd0, 6'd0);
    configure(ModeAtB, 7'd1, 7'd64, 7'd64);
    send_word(OpQuery, 12'd0, 16'sd0, 6'd63, 6'd0);
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int items);
    int r;
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      if (i % 60 == 0) configure(2'($urandom_range(3)), pick_dim(), pick_dim(), pick_dim());
      r = $urandom_range(99);
      if (r < 50) random_query();
      else if (r < 72) send_word(OpWriteA, 12'($urandom_range(63)), rand_elem(),
                                 6'($urandom), 6'($urandom));
      else if (r < 95) send_word(OpWriteB, 12'($urandom_range(63)), rand_elem(),
                                 6'($urandom), 6'($urandom));
      else send_word(2'd3, 12'($urandom), 16'($urandom), 6'($urandom), 6'($urandom));
    end
  endtask

  task automatic test_backpressure;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    configure(ModeABt, 7'd8, 7'd8, 7'd8);
    hold_cnt <= 400;
    for (int i = 0; i < 24; i++) random_query();
  endtask

  initial begin
    cur_mode = ModeAB;
    cur_m = 7'd64;
    cur_n = 7'd64;
    cur_k = 7'd64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_preload();
    test_saturation();
    test_special_settings();
    test_random_phase(0, 0, 150);
    test_random_phase(67, 0, 150);
    test_random_phase(0, 67, 150);
    test_random_phase(10, 10, 150);
    test_backpressure();
    drain();
    $display("Covered %0d element writes and %0d queries (%0d range errors) over all modes.",
             writes_sent, queries_sent, range_errors_seen);
    $display("Checked %0d result words; %0d mismatches.", entries_checked, mismatches);
    if (mismatches == 0) begin
      $display("** matrix_multiply_with_transpose: PASSED **");
    end else begin
      $display("** matrix_multiply_with_transpose: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", pending_entries.size());
    $display("** matrix_multiply_with_transpose: FAILED **");
    $finish;
  end

endmodule

### files.f
hdl/mmt_pkg.sv
hdl/mmt_ram.sv
hdl/mmt_front.sv
hdl/mmt_queue.sv
hdl/mmt_back.sv
hdl/matrix_multiply_with_transpose.sv
sim/matrix_multiply_with_transpose_test.sv
